[rtl/core/time_prefixed_line_indexer_core_defines.svh]
// ----------------------------------------------------------------------------
// Time-prefixed line indexer: assertion macros
// Shared property shorthands for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef TIME_PREFIXED_LINE_INDEXER_CORE_DEFINES_SVH
`define TIME_PREFIXED_LINE_INDEXER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPLI_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TPLI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/tpli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-prefixed line indexer: package
// Shared constants, controller/datapath interface types and head decoding.
// ----------------------------------------------------------------------------
package tpli_pkg;

  localparam int MINUTE_ENTRIES = 1440;
  localparam int MIN_AW         = $clog2(MINUTE_ENTRIES);
  localparam int POS_W          = 32;
  localparam int CNT_W          = 16;
  localparam int ENTRY_W        = POS_W + CNT_W;
  localparam int KIND_W         = 2;
  localparam int IDX_W          = 11;

  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam logic [2:0] HEAD_FULL = 3'd4;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_UPD_RD   = 6'b000100,
    ST_UPD_WR   = 6'b001000,
    ST_LOOK_RD  = 6'b010000,
    ST_LOOK_OUT = 6'b100000
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;
    logic take_look;
    logic clear_scan;
    logic rd_en;
    logic wr_upd;
    logic wr_clr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_hit;
    logic clr_last;
  } dp_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [12:0] head_minute(input logic [7:0] h0, input logic [7:0] h1,
                                              input logic [7:0] m0, input logic [7:0] m1);
    logic [6:0] hh;
    logic [6:0] mm;
    hh = 7'(h0[3:0]) * 7'd10 + 7'(h1[3:0]);
    mm = 7'(m0[3:0]) * 7'd10 + 7'(m1[3:0]);
    return 13'(hh) * 13'd60 + 13'(mm);
  endfunction

endpackage

[rtl/core/tpli_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-prefixed line indexer: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpli_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/tpli_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-prefixed line indexer: controller
// Sequences table sweeps, read-modify-write updates and lookups.
// ----------------------------------------------------------------------------
module tpli_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tpli_pkg::KIND_W-1:0]    in_kind,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  tpli_pkg::dp_status_t           status,
  output tpli_pkg::ctrl_cmd_t            cmd
);

  tpli_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;

  assign in_tready  = (state_r == tpli_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tpli_pkg::ST_CLEAR: begin
        cmd.wr_clr = 1'b1;
        if (status.clr_last) begin
          state_nxt = tpli_pkg::ST_IDLE;
        end
      end
      tpli_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            tpli_pkg::KIND_BYTE: begin
              cmd.take_byte = 1'b1;
              if (status.head_hit) begin
                state_nxt = tpli_pkg::ST_UPD_RD;
              end
            end
            tpli_pkg::KIND_LOOKUP: begin
              cmd.take_look = 1'b1;
              state_nxt     = tpli_pkg::ST_LOOK_RD;
            end
            tpli_pkg::KIND_CLEAR: begin
              cmd.clear_scan = 1'b1;
              state_nxt      = tpli_pkg::ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      tpli_pkg::ST_UPD_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tpli_pkg::ST_UPD_WR;
      end
      tpli_pkg::ST_UPD_WR: begin
        cmd.wr_upd = 1'b1;
        state_nxt  = tpli_pkg::ST_IDLE;
      end
      tpli_pkg::ST_LOOK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tpli_pkg::ST_LOOK_OUT;
      end
      tpli_pkg::ST_LOOK_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = tpli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tpli_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpli_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/tpli_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-prefixed line indexer: datapath
// Byte scanner, head decoder, minute table and result register.
// ----------------------------------------------------------------------------
module tpli_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    in_byte,
  input  logic [tpli_pkg::IDX_W-1:0]    in_minute,
  input  tpli_pkg::ctrl_cmd_t           cmd,
  output tpli_pkg::dp_status_t          status,
  output logic [tpli_pkg::POS_W-1:0]    out_offset,
  output logic [tpli_pkg::CNT_W-1:0]    out_count
);

  logic [tpli_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [tpli_pkg::POS_W-1:0]  line_start_r, line_start_nxt;
  logic                        capturing_r, capturing_nxt;
  logic [2:0]                  head_len_r, head_len_nxt;
  logic [7:0]                  head_r [4];
  logic [7:0]                  head_nxt [4];
  logic                        ready_r, ready_nxt;
  logic [tpli_pkg::MIN_AW-1:0] minute_r, minute_nxt;
  logic                        look_ok_r, look_ok_nxt;
  logic [tpli_pkg::MIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [tpli_pkg::POS_W-1:0]  out_offset_r;
  logic [tpli_pkg::CNT_W-1:0]  out_count_r;

  logic [12:0]                 minute_calc;
  logic                        head_match;
  logic [tpli_pkg::ENTRY_W-1:0] rd_word;
  logic [tpli_pkg::ENTRY_W-1:0] wr_word;
  logic [tpli_pkg::POS_W-1:0]  rd_offset;
  logic [tpli_pkg::CNT_W-1:0]  rd_count;
  logic [tpli_pkg::MIN_AW-1:0] waddr;
  logic                        look_in_range;

  assign minute_calc = tpli_pkg::head_minute(head_r[0], head_r[1], head_r[3], in_byte);
  assign head_match  = capturing_r && (head_len_r == tpli_pkg::HEAD_FULL) &&
                       (head_r[2] == tpli_pkg::CHAR_COLON) &&
                       tpli_pkg::is_digit(head_r[0]) && tpli_pkg::is_digit(head_r[1]) &&
                       tpli_pkg::is_digit(head_r[3]) && tpli_pkg::is_digit(in_byte) &&
                       (minute_calc < 13'(tpli_pkg::MINUTE_ENTRIES));

  assign look_in_range = (in_minute < tpli_pkg::IDX_W'(tpli_pkg::MINUTE_ENTRIES));

  assign status.head_hit = head_match;
  assign status.clr_last = (clr_cnt_r == tpli_pkg::MIN_AW'(tpli_pkg::MINUTE_ENTRIES - 1));

  always_comb begin
    pos_nxt        = pos_r;
    line_start_nxt = line_start_r;
    capturing_nxt  = capturing_r;
    head_len_nxt   = head_len_r;
    head_nxt       = head_r;
    ready_nxt      = ready_r;
    minute_nxt     = minute_r;
    look_ok_nxt    = look_ok_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (cmd.clear_scan) begin
      pos_nxt        = '0;
      line_start_nxt = '0;
      capturing_nxt  = 1'b1;
      head_len_nxt   = '0;
      head_nxt       = '{default: 8'h00};
      ready_nxt      = 1'b1;
      clr_cnt_nxt    = '0;
    end else if (cmd.take_byte) begin
      if (capturing_r) begin
        if (head_len_r < tpli_pkg::HEAD_FULL) begin
          head_nxt[head_len_r[1:0]] = in_byte;
          head_len_nxt              = head_len_r + 3'd1;
        end else begin
          capturing_nxt = 1'b0;
        end
      end
      if (in_byte == tpli_pkg::CHAR_NEWLINE) begin
        capturing_nxt  = 1'b1;
        head_len_nxt   = '0;
        line_start_nxt = pos_r + tpli_pkg::POS_W'(1);
      end
      pos_nxt = pos_r + tpli_pkg::POS_W'(1);
      if (head_match) begin
        minute_nxt = minute_calc[tpli_pkg::MIN_AW-1:0];
      end
    end else if (cmd.take_look) begin
      look_ok_nxt = ready_r && look_in_range;
      minute_nxt  = look_in_range ? in_minute[tpli_pkg::MIN_AW-1:0] : '0;
    end
    if (cmd.wr_clr) begin
      clr_cnt_nxt = clr_cnt_r + tpli_pkg::MIN_AW'(1);
    end
  end

  assign rd_offset = rd_word[tpli_pkg::POS_W-1:0];
  assign rd_count  = rd_word[tpli_pkg::ENTRY_W-1:tpli_pkg::POS_W];

  always_comb begin
    if (cmd.wr_clr) begin
      waddr   = clr_cnt_r;
      wr_word = '0;
    end else begin
      waddr   = minute_r;
      wr_word = {rd_count + tpli_pkg::CNT_W'(1),
                 (rd_count == '0) ? line_start_r : rd_offset};
    end
  end

  tpli_ram #(
    .WIDTH (tpli_pkg::ENTRY_W),
    .DEPTH (tpli_pkg::MINUTE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_clr || cmd.wr_upd),
    .waddr (waddr),
    .wdata (wr_word),
    .re    (cmd.rd_en),
    .raddr (minute_r),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      line_start_r <= '0;
      capturing_r  <= 1'b1;
      head_len_r   <= '0;
      head_r       <= '{default: 8'h00};
      ready_r      <= 1'b0;
      look_ok_r    <= 1'b0;
      clr_cnt_r    <= '0;
    end else begin
      pos_r        <= pos_nxt;
      line_start_r <= line_start_nxt;
      capturing_r  <= capturing_nxt;
      head_len_r   <= head_len_nxt;
      head_r       <= head_nxt;
      ready_r      <= ready_nxt;
      look_ok_r    <= look_ok_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    minute_r <= minute_nxt;
    if (cmd.load_out) begin
      if (look_ok_r && (rd_count != '0)) begin
        out_offset_r <= rd_offset;
        out_count_r  <= rd_count;
      end else begin
        out_offset_r <= '0;
        out_count_r  <= '0;
      end
    end
  end

  assign out_offset = out_offset_r;
  assign out_count  = out_count_r;

endmodule

[rtl/core/time_prefixed_line_indexer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-prefixed line indexer core
// Builds a per-minute line index from a text stream and answers lookups.
// ----------------------------------------------------------------------------
// Flow: a plain text byte is taken in IDLE and the core stays ready for the
// next one. A byte that completes a line head of the form DD:DD with a minute
// below 1440 also reads and then writes back its entry of the 1440-entry
// minute table, through its single read and single write port, before the next
// transaction. A lookup reads the table and then waits for the result register
// to drain. A clear transaction starts a sweep that zeroes the table; the same
// sweep runs after reset, and no transaction is taken while it runs. Lookups
// return zero until the first clear.
module time_prefixed_line_indexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [18:8] minute_index, [23:19] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] entry_offset, [47:32] entry_count
);

`include "time_prefixed_line_indexer_core_defines.svh"

  tpli_pkg::ctrl_cmd_t  cmd;
  tpli_pkg::dp_status_t status;
  logic [tpli_pkg::POS_W-1:0] out_offset;
  logic [tpli_pkg::CNT_W-1:0] out_count;

  tpli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tpli_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata[7:0]),
    .in_minute  (in_tdata[18:8]),
    .cmd        (cmd),
    .status     (status),
    .out_offset (out_offset),
    .out_count  (out_count)
  );

  assign out_tdata = {out_count, out_offset};

  `TPLI_ASSERT_NEXT(a_lookup_blocks, in_tvalid && in_tready && (in_tuser == tpli_pkg::KIND_LOOKUP), !in_tready, "lookup transaction did not hold off input")
  `TPLI_ASSERT_NEXT(a_clear_sweeps, in_tvalid && in_tready && (in_tuser == tpli_pkg::KIND_CLEAR), cmd.wr_clr && !in_tready, "clear transaction did not start sweep")
  `TPLI_ASSERT_NOW(a_no_accept_in_write, cmd.wr_clr || cmd.wr_upd || cmd.rd_en, !in_tready, "input accepted during table access")

endmodule
